>>> hw/rtl/wpm_pkg.sv
// wpm_pkg: shared types and constants for the wildcard pattern matcher
// no dependencies; imported by wpm_cell and wildcard_pattern_matcher
`default_nettype none

package wpm_pkg;

    typedef logic [7:0] char_t;
    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_CLEAR  = 2'd0;
    localparam cmd_t CMD_APPEND = 2'd1;
    localparam cmd_t CMD_TEXT   = 2'd2;
    localparam cmd_t CMD_FINISH = 2'd3;

    localparam char_t STAR_BYTE = 8'h2A;
    localparam char_t ANY_BYTE  = 8'h3F;

    // per-transfer controls broadcast to every cell
    typedef struct packed {
        logic  clear;
        logic  append;
        logic  step;
        logic  restore;
        char_t data;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/wpm_cell.sv
// wpm_cell: one pattern position of the matcher row (byte, match bit, start bit)
// depends on wpm_pkg; instantiated in a chain by wildcard_pattern_matcher
`default_nettype none

module wpm_cell #(
    parameter int INDEX = 1,
    parameter int LEN_W = 6
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wpm_pkg::cell_ctrl_t    ctrl,
    input  wire  [LEN_W-1:0]       length,
    input  wire                    carry_in,
    input  wire                    match_prev,
    input  wire                    start_prev,
    output logic                   carry_out,
    output logic                   match,
    output logic                   start
);
    import wpm_pkg::*;

    char_t byte_reg;
    logic  match_reg;
    logic  match_next;
    logic  start_reg;
    logic  start_next;
    logic  active;
    logic  load_here;
    logic  is_star;
    logic  hit;
    logic  start_load;

    assign active    = (length >= LEN_W'(INDEX));
    assign load_here = ctrl.append && (length == LEN_W'(INDEX - 1));
    assign is_star   = (byte_reg == STAR_BYTE);
    assign hit       = (byte_reg == ANY_BYTE) || (byte_reg == ctrl.data);

    // star cells pass the row value along like a carry, others start it afresh
    always_comb
    begin
        if (!active)
        begin
            carry_out = 1'b0;
        end
        else if (is_star)
        begin
            carry_out = carry_in | match_reg;
        end
        else
        begin
            carry_out = hit & match_prev;
        end
    end

    assign start_load = (ctrl.data == STAR_BYTE) ? start_prev : 1'b0;

    always_comb
    begin
        match_next = match_reg;
        start_next = start_reg;
        if (ctrl.clear)
        begin
            match_next = 1'b0;
            start_next = 1'b0;
        end
        else if (load_here)
        begin
            match_next = start_load;
            start_next = start_load;
        end
        else if (ctrl.step)
        begin
            match_next = carry_out;
        end
        else if (ctrl.restore)
        begin
            match_next = start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            byte_reg <= ctrl.data;
        end
    end

    assign match = match_reg;
    assign start = start_reg;

endmodule

`default_nettype wire

>>> hw/rtl/wildcard_pattern_matcher.sv
// wildcard_pattern_matcher: streaming glob matcher ('*' any run, '?' any byte)
// depends on wpm_pkg and wpm_cell (one cell per pattern position)
//
// usage
//   input channel in_valid/in_ready carries command and char_value:
//   clear pattern, append pattern byte, text byte, finish and report.
//   output channel out_valid/out_ready carries matched and pattern_error,
//   one transfer for each finish command and none for the others.
//   one input transfer per clock is taken while the output register is
//   empty or being drained. a finish result is shown on the cycle after
//   its input transfer. each text byte updates the whole row as it is
//   taken; runs of '*' pass their bit along the cell chain like a carry,
//   so the chain length (MAX_PATTERN cells) sets the clock period.
//   in_ready drops while a result is held and out_ready is low, so a
//   stalled receiver holds back further input. appends beyond capacity or
//   after text has begun are dropped and flagged in pattern_error.
//   reset empties the pattern, clears the error flag and the output
//   valid flag; no clearing pass is needed.
`default_nettype none

module wildcard_pattern_matcher #(
    parameter int MAX_PATTERN = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wpm_pkg::cmd_t          command,
    input  wpm_pkg::char_t         char_value,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic                   matched,
    output logic                   pattern_error
);
    import wpm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    cell_ctrl_t           ctrl;
    logic                 accept;
    logic                 do_append;
    logic                 full;
    logic [LEN_W-1:0]     length_reg;
    logic [LEN_W-1:0]     length_next;
    logic                 match0_reg;
    logic                 match0_next;
    logic                 begun_reg;
    logic                 begun_next;
    logic                 error_reg;
    logic                 error_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 matched_reg;
    logic                 pattern_error_reg;
    logic [MAX_PATTERN:0] carry;
    logic [MAX_PATTERN:0] match_row;
    logic [MAX_PATTERN:0] start_row;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign full      = (length_reg == LEN_W'(MAX_PATTERN));
    assign do_append = accept && (command == CMD_APPEND) && !begun_reg;

    assign ctrl.clear   = accept && (command == CMD_CLEAR);
    assign ctrl.append  = do_append;
    assign ctrl.step    = accept && (command == CMD_TEXT);
    assign ctrl.restore = accept && (command == CMD_FINISH);
    assign ctrl.data    = char_value;

    // position zero: the empty pattern prefix
    assign carry[0]     = 1'b0;
    assign match_row[0] = match0_reg;
    assign start_row[0] = 1'b1;

    for (genvar j = 1; j <= MAX_PATTERN; j++)
    begin : g_cell
        wpm_cell #(
            .INDEX (j),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .length     (length_reg),
            .carry_in   (carry[j-1]),
            .match_prev (match_row[j-1]),
            .start_prev (start_row[j-1]),
            .carry_out  (carry[j]),
            .match      (match_row[j]),
            .start      (start_row[j])
        );
    end

    always_comb
    begin
        length_next = length_reg;
        match0_next = match0_reg;
        begun_next  = begun_reg;
        error_next  = error_reg;
        if (accept)
        begin
            case (command)
                CMD_CLEAR:
                begin
                    length_next = '0;
                    match0_next = 1'b1;
                    begun_next  = 1'b0;
                    error_next  = 1'b0;
                end
                CMD_APPEND:
                begin
                    if (begun_reg || full)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        length_next = length_reg + LEN_W'(1);
                    end
                end
                CMD_TEXT:
                begin
                    match0_next = 1'b0;
                    begun_next  = 1'b1;
                end
                CMD_FINISH:
                begin
                    match0_next = 1'b1;
                    begun_next  = 1'b0;
                end
                default:
                begin
                    length_next = length_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.restore)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            match0_reg    <= 1'b1;
            begun_reg     <= 1'b0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            match0_reg    <= match0_next;
            begun_reg     <= begun_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded on a finish transfer
    always_ff @(posedge clk)
    begin
        if (ctrl.restore)
        begin
            matched_reg       <= match_row[length_reg];
            pattern_error_reg <= error_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign matched       = matched_reg;
    assign pattern_error = pattern_error_reg;

endmodule

`default_nettype wire
